[hdl/rcs_pkg.sv]
`default_nettype none

package rcs_pkg;

    localparam int DATA_W          = 24;
    localparam int SUM_W           = 41;
    localparam int SQ_W            = 2 * DATA_W;
    localparam int SUM2_W          = 64;
    localparam int ITER_W          = $clog2(SUM2_W);
    localparam int MEAN_PAD        = SUM2_W - SUM_W;
    localparam int MAX_SAMPLES_DEF = 65536;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    // register word index within the configuration space
    localparam logic REG_SAMPLE_OFFSET = 1'b0;

    // iteration counter start points; every sequence ends at all ones
    localparam logic [ITER_W-1:0] ITER_DIV_SQ   = '0;
    localparam logic [ITER_W-1:0] ITER_DIV_MEAN = ITER_W'(MEAN_PAD);
    localparam logic [ITER_W-1:0] ITER_ROOT     = ITER_W'(SUM2_W / 2);

    localparam logic [SUM2_W-1:0] ROOT_BIT_INIT = {2'b01, {(SUM2_W - 2){1'b0}}};

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_LOAD_SQ,
        ST_DIV_SQ,
        ST_LOAD_MEAN,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MEAN_SQ,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_load_sq;
        logic div_load_mean;
        logic div_step;
        logic mean_fix;
        logic mean_sq;
        logic root_load;
        logic root_step;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic last_retired;
        logic step_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[hdl/running_column_statistics.sv]
// channel   | dir | handshake                   | content
// ----------+-----+-----------------------------+-------------------------------------
// s_axis    | in  | tvalid / tready             | tdata: sample; tlast: last of run
// m_axis    | out | tvalid / tready             | tdata: mean, std_dev, largest,
//           |     |                             |        smallest; tuser: overflowed
// apb       | in  | psel / penable / pready     | sample_offset at byte address 0
//
// one sample per cycle; after the tlast transfer tready stays low until the statistics are done:
// a 64-step division of the square sum, a 41-step division of the sum and a 32-step
// square root, sharing one iteration counter in the datapath
// the result waits in an output register; the next run may start while it is held,
// but its result keeps tready low until the held one is taken
// reset is synchronous, active low; it clears the run and sets the offset to zero
`default_nettype none

module running_column_statistics #(
    parameter int MAX_SAMPLES = rcs_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rcs_pkg::DATA_W-1:0]        s_axis_tdata,  // [23:0] sample
    input  wire logic                              s_axis_tlast,

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [23:0] mean, [47:24] std_dev, [71:48] largest, [95:72] smallest
    output logic [4*rcs_pkg::DATA_W-1:0]           m_axis_tdata,
    output logic                                   m_axis_tuser,  // [0] overflowed

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [rcs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rcs_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int DW = rcs_pkg::DATA_W;

    logic [DW-1:0]     r_offset;
    logic              w_cfg_hit;

    rcs_pkg::t_cmd     w_cmd;
    rcs_pkg::t_status  w_status;

    logic [DW-1:0]     w_mean;
    logic [DW-1:0]     w_std_dev;
    logic [DW-1:0]     w_largest;
    logic [DW-1:0]     w_smallest;

    assign pready    = 1'b1;
    assign w_cfg_hit = paddr[2] == rcs_pkg::REG_SAMPLE_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (psel && penable && pwrite && pready && w_cfg_hit) begin
            r_offset <= pwdata[DW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_cfg_hit) begin
            prdata = {{(rcs_pkg::CFG_DATA_W - DW){r_offset[DW-1]}}, r_offset};
        end
    end

    rcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    rcs_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample     (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_offset     (r_offset),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_mean       (w_mean),
        .o_std_dev    (w_std_dev),
        .o_largest    (w_largest),
        .o_smallest   (w_smallest),
        .o_overflowed (m_axis_tuser)
    );

    assign m_axis_tdata = {w_smallest, w_largest, w_std_dev, w_mean};

endmodule

`default_nettype wire

[hdl/rcs_ctrl.sv]
`default_nettype none

module rcs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_valid,
    input  wire logic            i_s_last,
    output logic                 o_s_ready,
    input  rcs_pkg::t_status     i_status,
    output rcs_pkg::t_cmd        o_cmd
);

    rcs_pkg::t_state r_state;
    rcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcs_pkg::ST_ACCUM: begin
                if (i_s_valid && i_s_last) begin
                    n_state = rcs_pkg::ST_DRAIN;
                end
            end
            rcs_pkg::ST_DRAIN: begin
                if (i_status.last_retired) begin
                    n_state = rcs_pkg::ST_LOAD_SQ;
                end
            end
            rcs_pkg::ST_LOAD_SQ:   n_state = rcs_pkg::ST_DIV_SQ;
            rcs_pkg::ST_DIV_SQ: begin
                if (i_status.step_done) begin
                    n_state = rcs_pkg::ST_LOAD_MEAN;
                end
            end
            rcs_pkg::ST_LOAD_MEAN: n_state = rcs_pkg::ST_DIV_MEAN;
            rcs_pkg::ST_DIV_MEAN: begin
                if (i_status.step_done) begin
                    n_state = rcs_pkg::ST_MEAN;
                end
            end
            rcs_pkg::ST_MEAN:      n_state = rcs_pkg::ST_MEAN_SQ;
            rcs_pkg::ST_MEAN_SQ:   n_state = rcs_pkg::ST_ROOT_LOAD;
            rcs_pkg::ST_ROOT_LOAD: n_state = rcs_pkg::ST_ROOT;
            rcs_pkg::ST_ROOT: begin
                if (i_status.step_done) begin
                    n_state = rcs_pkg::ST_RESULT;
                end
            end
            rcs_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    n_state = rcs_pkg::ST_ACCUM;
                end
            end
            default: n_state = rcs_pkg::ST_ACCUM;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            rcs_pkg::ST_ACCUM: begin
                o_s_ready    = 1'b1;
                o_cmd.accept = i_s_valid;
            end
            rcs_pkg::ST_DRAIN:     ;
            rcs_pkg::ST_LOAD_SQ:   o_cmd.div_load_sq   = 1'b1;
            rcs_pkg::ST_DIV_SQ:    o_cmd.div_step      = 1'b1;
            rcs_pkg::ST_LOAD_MEAN: o_cmd.div_load_mean = 1'b1;
            rcs_pkg::ST_DIV_MEAN:  o_cmd.div_step      = 1'b1;
            rcs_pkg::ST_MEAN:      o_cmd.mean_fix      = 1'b1;
            rcs_pkg::ST_MEAN_SQ:   o_cmd.mean_sq       = 1'b1;
            rcs_pkg::ST_ROOT_LOAD: o_cmd.root_load     = 1'b1;
            rcs_pkg::ST_ROOT:      o_cmd.root_step     = 1'b1;
            rcs_pkg::ST_RESULT:    o_cmd.result_load   = i_status.out_free;
            default:               o_cmd               = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/rcs_dp.sv]
`default_nettype none

module rcs_dp #(
    parameter int MAX_SAMPLES = rcs_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  rcs_pkg::t_cmd                      i_cmd,
    output rcs_pkg::t_status                   o_status,
    input  wire logic [rcs_pkg::DATA_W-1:0]    i_sample,
    input  wire logic                          i_last,
    input  wire logic [rcs_pkg::DATA_W-1:0]    i_offset,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [rcs_pkg::DATA_W-1:0]         o_mean,
    output logic [rcs_pkg::DATA_W-1:0]         o_std_dev,
    output logic [rcs_pkg::DATA_W-1:0]         o_largest,
    output logic [rcs_pkg::DATA_W-1:0]         o_smallest,
    output logic                               o_overflowed
);

    localparam int DW     = rcs_pkg::DATA_W;
    localparam int SW     = rcs_pkg::SUM_W;
    localparam int QW     = rcs_pkg::SQ_W;
    localparam int S2W    = rcs_pkg::SUM2_W;
    localparam int IW     = rcs_pkg::ITER_W;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    // input stage: offset and saturate
    logic signed [DW:0]   w_add;
    logic                 n_sat;
    logic signed [DW-1:0] n_x;

    logic                 r_x_vld;
    logic                 r_x_last;
    logic                 r_x_sat;
    logic signed [DW-1:0] r_x;

    // accumulation
    logic                 w_keep;
    logic [CNT_W-1:0]     r_count;
    logic signed [SW-1:0] r_sum;
    logic [S2W-1:0]       r_sum2;
    logic signed [DW-1:0] r_max;
    logic signed [DW-1:0] r_min;
    logic                 r_ovf;

    // shared squarer
    logic signed [DW-1:0] w_mul_a;
    logic signed [QW-1:0] w_prod;
    logic [QW-1:0]        r_sq;
    logic                 r_sq_vld;
    logic                 r_sq_last;

    // shared divider, restoring, one quotient bit per step
    logic [S2W-1:0]       r_dvd;
    logic [CNT_W-1:0]     r_rem;
    logic [IW-1:0]        r_iter;
    logic [CNT_W:0]       w_shift;
    logic [CNT_W:0]       w_diff;
    logic                 w_ge;
    logic [SW-1:0]        w_sum_abs;
    logic [S2W-1:0]       r_ms;
    logic signed [DW-1:0] r_mean;

    // square root, two radicand bits per step
    logic [S2W-1:0]       w_m2;
    logic [S2W-1:0]       r_rad;
    logic [S2W-1:0]       r_root;
    logic [S2W-1:0]       r_bit;
    logic [S2W-1:0]       w_trial;
    logic                 w_rge;
    logic [DW-1:0]        w_sd;
    logic                 w_empty;

    logic                 r_out_vld;
    logic [DW-1:0]        r_mean_o;
    logic [DW-1:0]        r_sd_o;
    logic [DW-1:0]        r_max_o;
    logic [DW-1:0]        r_min_o;
    logic                 r_ovf_o;

    assign w_add = $signed({i_sample[DW-1], i_sample}) + $signed({i_offset[DW-1], i_offset});
    assign n_sat = w_add[DW] != w_add[DW-1];

    always_comb begin
        if (!n_sat) begin
            n_x = w_add[DW-1:0];
        end else if (w_add[DW]) begin
            n_x = rcs_pkg::S_MIN;
        end else begin
            n_x = rcs_pkg::S_MAX;
        end
    end

    assign w_keep  = r_count < CNT_MAX;
    assign w_mul_a = i_cmd.mean_sq ? r_mean : r_x;
    assign w_prod  = w_mul_a * w_mul_a;

    assign w_shift   = {r_rem, r_dvd[S2W-1]};
    assign w_ge      = w_shift >= {1'b0, r_count};
    assign w_diff    = w_shift - {1'b0, r_count};
    assign w_sum_abs = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);

    assign w_m2    = S2W'(r_sq);
    assign w_trial = r_root + r_bit;
    assign w_rge   = r_rad >= w_trial;
    assign w_sd    = (|r_root[S2W-1:DW]) ? {DW{1'b1}} : r_root[DW-1:0];
    assign w_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld   <= 1'b0;
            r_sq_vld  <= 1'b0;
            r_sq_last <= 1'b0;
            r_count   <= '0;
            r_sum     <= '0;
            r_sum2    <= '0;
            r_max     <= rcs_pkg::S_MIN;
            r_min     <= rcs_pkg::S_MAX;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_x_vld   <= i_cmd.accept;
            r_sq_vld  <= r_x_vld && w_keep;
            r_sq_last <= r_x_vld && r_x_last;

            if (r_x_vld) begin
                if (w_keep) begin
                    r_count <= r_count + CNT_W'(1);
                    r_sum   <= r_sum + SW'(r_x);
                    if (r_x > r_max) begin
                        r_max <= r_x;
                    end
                    if (r_x < r_min) begin
                        r_min <= r_x;
                    end
                end
                if (r_x_sat || !w_keep) begin
                    r_ovf <= 1'b1;
                end
            end

            if (r_sq_vld) begin
                r_sum2 <= r_sum2 + S2W'(r_sq);
            end

            if (i_cmd.result_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            // pipeline is empty here, so clearing cannot lose a sample
            if (i_cmd.result_load) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sum2  <= '0;
                r_max   <= rcs_pkg::S_MIN;
                r_min   <= rcs_pkg::S_MAX;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x      <= n_x;
            r_x_last <= i_last;
            r_x_sat  <= n_sat;
        end

        if (r_x_vld || i_cmd.mean_sq) begin
            r_sq <= w_prod;
        end

        if (i_cmd.div_load_sq) begin
            r_dvd  <= r_sum2;
            r_rem  <= '0;
            r_iter <= rcs_pkg::ITER_DIV_SQ;
        end else if (i_cmd.div_load_mean) begin
            r_ms   <= r_dvd;
            r_dvd  <= {w_sum_abs, {rcs_pkg::MEAN_PAD{1'b0}}};
            r_rem  <= '0;
            r_iter <= rcs_pkg::ITER_DIV_MEAN;
        end else if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[S2W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            r_iter <= r_iter + IW'(1);
        end else if (i_cmd.root_load) begin
            r_iter <= rcs_pkg::ITER_ROOT;
        end else if (i_cmd.root_step) begin
            r_iter <= r_iter + IW'(1);
        end

        if (i_cmd.mean_fix) begin
            // quotient truncates toward zero, sign comes back afterwards
            r_mean <= r_sum[SW-1] ? -r_dvd[DW-1:0] : r_dvd[DW-1:0];
        end

        if (i_cmd.root_load) begin
            r_rad  <= (r_ms > w_m2) ? r_ms - w_m2 : '0;
            r_root <= '0;
            r_bit  <= rcs_pkg::ROOT_BIT_INIT;
        end else if (i_cmd.root_step) begin
            if (w_rge) begin
                r_rad  <= r_rad - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        if (i_cmd.result_load) begin
            r_mean_o <= w_empty ? '0 : r_mean;
            r_sd_o   <= w_empty ? '0 : w_sd;
            r_max_o  <= r_max;
            r_min_o  <= r_min;
            r_ovf_o  <= r_ovf;
        end
    end

    assign o_status.last_retired = r_sq_last;
    assign o_status.step_done    = &r_iter;
    assign o_status.out_free     = !r_out_vld || i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_mean       = r_mean_o;
    assign o_std_dev    = r_sd_o;
    assign o_largest    = r_max_o;
    assign o_smallest   = r_min_o;
    assign o_overflowed = r_ovf_o;

endmodule

`default_nettype wire
